// File: sv/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Holds event codes, register indexes and the tracking-state record; no dependencies.
package bdpc_pkg;

  // Field widths
  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int AddrW  = 2;
  localparam int InW    = 40;   // pin_level + now_ms, padded to whole bytes
  localparam int OutW   = 8;    // press_event, padded to whole bytes

  // Configuration register indexes
  localparam logic [AddrW-1:0] RegActiveLow = 2'd0;
  localparam logic [AddrW-1:0] RegDebounce  = 2'd1;
  localparam logic [AddrW-1:0] RegLongPress = 2'd2;

  // Configuration reset values
  localparam logic            ActiveLowRst = 1'b1;
  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst = 16'd1000;

  // Press event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  // Button tracking state
  typedef struct packed {
    logic             last_raw;
    logic             stable_pressed;
    logic             long_reported;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] press_start;
  } btn_state_t;

  // Active configuration
  typedef struct packed {
    logic            active_low;
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
  } btn_cfg_t;

endpackage

// File: sv/bdpc_classify.sv
// Combinational debounce and press classification for one poll.
// Depends on bdpc_pkg for the state record, configuration and event codes.
module bdpc_classify
  import bdpc_pkg::*;
(
  input  btn_cfg_t         cfg,
  input  btn_state_t       cur,
  input  logic             pin_level,
  input  logic [TimeW-1:0] now_ms,
  output btn_state_t       nxt,
  output press_event_t     press_event
);

  logic             pressed;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] since_press;
  logic             debounced;
  logic             long_due;

  // Map pin level and measure elapsed times (wrapping)
  assign pressed      = cfg.active_low ? ~pin_level : pin_level;
  assign since_change = now_ms - cur.change_time;
  assign since_press  = now_ms - cur.press_start;
  assign debounced    = (since_change >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time});
  assign long_due     = (since_press >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_time});

  // Pick next state and event
  always_comb begin
    nxt         = cur;
    press_event = EV_NONE;
    if (pressed != cur.last_raw) begin
      // restart the debounce window
      nxt.last_raw    = pressed;
      nxt.change_time = now_ms;
    end else if (pressed != cur.stable_pressed && debounced) begin
      nxt.stable_pressed = pressed;
      if (pressed) begin
        nxt.press_start   = now_ms;
        nxt.long_reported = 1'b0;
      end else if (!cur.long_reported) begin
        press_event = EV_SHORT;
      end
    end else if (cur.stable_pressed && !cur.long_reported && long_due) begin
      nxt.long_reported = 1'b1;
      press_event       = EV_LONG;
    end
  end

endmodule

// File: sv/button_debounce_press_classifier.sv
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg and bdpc_classify.
//
// Each poll request carries the raw pin level and a millisecond timestamp and
// yields exactly one result, the press event (none, short or long). A poll is
// registered on entry, classified combinationally against the tracking state
// and lands in the output register, so one poll is taken per clock while the
// output is not held by m_tready; the rate is set by the single state update
// per cycle. The input stage keeps accepting while a result waits as long as
// it can move on. Configuration writes go through cfg_we/cfg_addr/cfg_wdata
// and must only be made while no poll is in flight.
module button_debounce_press_classifier
  import bdpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // poll input
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [InW-1:0]   s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // event output
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OutW-1:0]  m_tdata,   // [1:0] press_event, [7:2] zero
  // configuration
  input  logic             cfg_we,
  input  logic [AddrW-1:0] cfg_addr,
  input  logic [CfgW-1:0]  cfg_wdata
);

  btn_cfg_t         cfg;
  btn_state_t       st;
  btn_state_t       st_next;
  press_event_t     ev_next;
  press_event_t     out_event;
  logic             in_valid;
  logic             in_level;
  logic [TimeW-1:0] in_time;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low      <= ActiveLowRst;
      cfg.debounce_time   <= DebounceRst;
      cfg.long_press_time <= LongPressRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegActiveLow: cfg.active_low      <= cfg_wdata[0];
        RegDebounce:  cfg.debounce_time   <= cfg_wdata;
        RegLongPress: cfg.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Move a registered poll into the output register when it is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[TimeW:1];
    end
  end

  bdpc_classify u_classify (
    .cfg         (cfg),
    .cur         (st),
    .pin_level   (in_level),
    .now_ms      (in_time),
    .nxt         (st_next),
    .press_event (ev_next)
  );

  // Tracking state, advanced once per classified poll
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= ev_next;
    end
  end

  assign m_tdata = {{(OutW-2){1'b0}}, out_event};

  // An empty output register never holds back the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // A long press leaves the long flag set
  a_long_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && ev_next == EV_LONG) |=> st.long_reported)
    else $error("long press without long flag");

  // A short press only comes with a stable release
  a_short_releases: assert property (@(posedge clk) disable iff (rst)
    (advance && ev_next == EV_SHORT) |=> (!st.stable_pressed && !st.long_reported))
    else $error("short press without stable release");

  // A raw level change never produces an event
  a_change_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && st_next.last_raw != st.last_raw) |-> ev_next == EV_NONE)
    else $error("event on raw level change");

endmodule
